// ----- sv/tld_pkg.sv -----
package tld_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;

    localparam logic [1:0] ACT_RECEIVE  = 2'd0;
    localparam logic [1:0] ACT_TRANSMIT = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;

    localparam logic [2:0] STS_OK    = 3'd0;
    localparam logic [2:0] STS_HELD  = 3'd1;
    localparam logic [2:0] STS_DROP  = 3'd2;
    localparam logic [2:0] STS_FULL  = 3'd3;
    localparam logic [2:0] STS_EMPTY = 3'd4;

    localparam logic [6:0] CH_INTR   = 7'h03;
    localparam logic [6:0] CH_EOF    = 7'h04;
    localparam logic [6:0] CH_BEL    = 7'h07;
    localparam logic [6:0] CH_BS     = 7'h08;
    localparam logic [6:0] CH_LF     = 7'h0a;
    localparam logic [6:0] CH_CR     = 7'h0d;
    localparam logic [6:0] CH_FLUSH  = 7'h0f;
    localparam logic [6:0] CH_RESUME = 7'h11;
    localparam logic [6:0] CH_STOP   = 7'h13;
    localparam logic [6:0] CH_SPACE  = 7'h20;

    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       load_out;
        logic [1:0] sel;
    } tld_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [1:0] last_sel;
    } tld_sts_t;

endpackage

// ----- sv/tty_line_discipline_top.sv -----
// terminal line discipline with canonical input editing
// input channel s_*: one word per action (receive, transmit, read), with the
// byte and the final-byte mark of a transmit request
// result channel m_*: one to three words per action, each with at most one
// character for the line; m_last marks the final word of an action
// the input word and the queue ram read are registered on accept, the
// execute step registers the results, and the first result word is then
// loaded into the output register
// an action with n result words runs as an accept step that issues the
// queue ram read, an execute step on the registered read data, and one
// output register load per result word
// a stalled receiver holds the output register and the sequencer waits;
// the next input word is taken as soon as the last result word is loaded
// reset clears stop and flush flags, queue head and fill count; the queue
// ram itself is not cleared
module tty_line_discipline_top import tld_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_valid,
    output logic [7:0] m_out_char,
    output logic       m_last,
    output logic       m_interrupt_request,
    output logic       m_line_ready,
    output logic       m_stopped,
    output logic       m_flushing,
    output logic [2:0] m_status,
    output logic [6:0] m_read_char,
    output logic       m_write_done,
    output logic [7:0] m_queue_count
);

    tld_cmd_t cmd;
    tld_sts_t sts;

    tld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tld_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_action            (s_action),
        .s_data_byte         (s_data_byte),
        .s_final_byte        (s_final_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_valid         (m_out_valid),
        .m_out_char          (m_out_char),
        .m_last              (m_last),
        .m_interrupt_request (m_interrupt_request),
        .m_line_ready        (m_line_ready),
        .m_stopped           (m_stopped),
        .m_flushing          (m_flushing),
        .m_status            (m_status),
        .m_read_char         (m_read_char),
        .m_write_done        (m_write_done),
        .m_queue_count       (m_queue_count)
    );

endmodule

// ----- sv/tld_ram.sv -----
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tld_ctrl.sv -----
module tld_ctrl import tld_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tld_sts_t sts,
    output tld_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        cmd.sel      = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                k_next     = 2'd0;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (k_reg == sts.last_sel) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ----- sv/tld_dp.sv -----
module tld_dp import tld_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  tld_cmd_t   cmd,
    output tld_sts_t   sts,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_valid,
    output logic [7:0] m_out_char,
    output logic       m_last,
    output logic       m_interrupt_request,
    output logic       m_line_ready,
    output logic       m_stopped,
    output logic       m_flushing,
    output logic [2:0] m_status,
    output logic [6:0] m_read_char,
    output logic       m_write_done,
    output logic [7:0] m_queue_count
);

    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

    // control state
    logic              stop_reg, stop_next;
    logic              flush_reg, flush_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              m_valid_reg;

    // captured word and per-item results
    logic [1:0]        act_reg;
    logic [7:0]        byte_reg;
    logic              fin_reg;
    logic [7:0]        e_reg [3];
    logic [7:0]        e_next [3];
    logic [1:0]        ecnt_reg, ecnt_next;
    logic              irq_reg, irq_next;
    logic              rdy_reg, rdy_next;
    logic [2:0]        sts_reg, sts_next;
    logic [6:0]        rchar_reg, rchar_next;
    logic              done_reg, done_next;

    // output register
    logic              o_valid_reg;
    logic [7:0]        o_char_reg;
    logic              o_last_reg;
    logic              o_irq_reg;
    logic              o_rdy_reg;
    logic              o_stop_reg;
    logic              o_flush_reg;
    logic [2:0]        o_sts_reg;
    logic [6:0]        o_rchar_reg;
    logic              o_done_reg;
    logic [7:0]        o_count_reg;

    // queue addressing
    logic [SUM_W-1:0]  push_sum, tail_sum, head_sum;
    logic [IDX_W-1:0]  push_idx, tail_idx, head_inc, raddr;
    logic              we;
    logic [6:0]        rdata;
    logic [6:0]        c, cq;
    logic              is_nl, full;

    always_comb begin
        push_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        tail_sum = push_sum - SUM_W'(1);
        head_sum = SUM_W'(head_reg) + SUM_W'(1);
        push_idx = IDX_W'((push_sum >= DEPTH_S) ? push_sum - DEPTH_S : push_sum);
        tail_idx = IDX_W'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
        head_inc = IDX_W'((head_sum >= DEPTH_S) ? head_sum - DEPTH_S : head_sum);
        raddr    = (s_action == ACT_RECEIVE) ? tail_idx : head_reg;
    end

    tld_ram #(
        .WIDTH (7),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (we),
        .waddr (push_idx),
        .wdata (cq),
        .re    (cmd.capture),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        c          = byte_reg[6:0];
        is_nl      = (c == CH_CR) || (c == CH_LF);
        cq         = is_nl ? CH_LF : c;
        full       = (fill_reg == FILL_W'(QUEUE_DEPTH));
        stop_next  = stop_reg;
        flush_next = flush_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        we         = 1'b0;
        e_next[0]  = 8'd0;
        e_next[1]  = 8'd0;
        e_next[2]  = 8'd0;
        ecnt_next  = 2'd0;
        irq_next   = 1'b0;
        rdy_next   = 1'b0;
        sts_next   = STS_OK;
        rchar_next = 7'd0;
        done_next  = 1'b0;
        unique case (act_reg)
            ACT_RECEIVE: begin
                priority if (c == CH_INTR) begin
                    irq_next = 1'b1;
                end else if (c == CH_FLUSH) begin
                    flush_next = ~flush_reg;
                end else if (c == CH_STOP) begin
                    stop_next = 1'b1;
                end else if (c == CH_RESUME) begin
                    stop_next = 1'b0;
                end else if (c == CH_BS) begin
                    if (fill_reg == '0) begin
                        sts_next = STS_EMPTY;
                    end else if (rdata != CH_LF) begin
                        fill_next = fill_reg - FILL_W'(1);
                        e_next[0] = {1'b0, CH_BS};
                        e_next[1] = {1'b0, CH_SPACE};
                        e_next[2] = {1'b0, CH_BS};
                        ecnt_next = 2'd3;
                    end
                end else begin
                    if (is_nl) begin
                        e_next[0] = {1'b0, CH_CR};
                        ecnt_next = 2'd2;
                    end else begin
                        ecnt_next = 2'd1;
                    end
                    if (!full) begin
                        we        = cmd.exec;
                        fill_next = fill_reg + FILL_W'(1);
                        if (is_nl) begin
                            e_next[1] = {1'b0, cq};
                        end else begin
                            e_next[0] = {1'b0, cq};
                        end
                    end else begin
                        sts_next = STS_FULL;
                        if (is_nl) begin
                            e_next[1] = {1'b0, CH_BEL};
                        end else begin
                            e_next[0] = {1'b0, CH_BEL};
                        end
                    end
                    rdy_next = (cq == CH_LF) || (cq == CH_EOF);
                end
            end
            ACT_TRANSMIT: begin
                if (stop_reg) begin
                    sts_next = STS_HELD;
                end else begin
                    done_next = fin_reg;
                    if (flush_reg) begin
                        sts_next = STS_DROP;
                    end else if (byte_reg == {1'b0, CH_LF}) begin
                        e_next[0] = {1'b0, CH_CR};
                        e_next[1] = byte_reg;
                        ecnt_next = 2'd2;
                    end else begin
                        e_next[0] = byte_reg;
                        ecnt_next = 2'd1;
                    end
                end
            end
            ACT_READ: begin
                if (fill_reg == '0) begin
                    sts_next = STS_EMPTY;
                end else begin
                    rchar_next = rdata;
                    head_next  = head_inc;
                    fill_next  = fill_reg - FILL_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg    <= 1'b0;
            flush_reg   <= 1'b0;
            head_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                stop_reg  <= stop_next;
                flush_reg <= flush_next;
                head_reg  <= head_next;
                fill_reg  <= fill_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_action;
            byte_reg <= s_data_byte;
            fin_reg  <= s_final_byte;
        end
        if (cmd.exec) begin
            e_reg[0]  <= e_next[0];
            e_reg[1]  <= e_next[1];
            e_reg[2]  <= e_next[2];
            ecnt_reg  <= ecnt_next;
            irq_reg   <= irq_next;
            rdy_reg   <= rdy_next;
            sts_reg   <= sts_next;
            rchar_reg <= rchar_next;
            done_reg  <= done_next;
        end
        if (cmd.load_out) begin
            o_valid_reg <= (cmd.sel < ecnt_reg);
            o_char_reg  <= (cmd.sel < ecnt_reg) ? e_reg[cmd.sel] : 8'd0;
            o_last_reg  <= (cmd.sel == sts.last_sel);
            o_irq_reg   <= irq_reg;
            o_rdy_reg   <= rdy_reg;
            o_stop_reg  <= stop_reg;
            o_flush_reg <= flush_reg;
            o_sts_reg   <= sts_reg;
            o_rchar_reg <= rchar_reg;
            o_done_reg  <= done_reg;
            o_count_reg <= 8'(fill_reg);
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.last_sel = (ecnt_reg == 2'd0) ? 2'd0 : ecnt_reg - 2'd1;

    assign m_valid             = m_valid_reg;
    assign m_out_valid         = o_valid_reg;
    assign m_out_char          = o_char_reg;
    assign m_last              = o_last_reg;
    assign m_interrupt_request = o_irq_reg;
    assign m_line_ready        = o_rdy_reg;
    assign m_stopped           = o_stop_reg;
    assign m_flushing          = o_flush_reg;
    assign m_status            = o_sts_reg;
    assign m_read_char         = o_rchar_reg;
    assign m_write_done        = o_done_reg;
    assign m_queue_count       = o_count_reg;

endmodule
